/* rtl/core/shns_pkg.sv */
// Shared types and constants of the spatial hash neighbor search core.
// No dependencies; used by shns_div and spatial_hash_neighbor_search_core.
package shns_pkg;

  // Command codes carried by in_mode.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_NEIGHBOR  = 3'd0;
  localparam logic [2:0] KIND_NONE      = 3'd1;
  localparam logic [2:0] KIND_BUILT     = 3'd2;
  localparam logic [2:0] KIND_REJECTED  = 3'd3;
  localparam logic [2:0] KIND_NOT_BUILT = 3'd4;

  // Hash multipliers and result limit.
  localparam logic signed [24:0] HASH_MUL_X = 25'sd15823;
  localparam logic signed [24:0] HASH_MUL_Y = 25'sd9737333;
  localparam int unsigned RESULT_CAP = 64;

  // Divider widths.
  localparam int unsigned DIV_NW = 32;
  localparam int unsigned DIV_DW = 23;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/core/shns_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on shns_pkg for the request and response structs.
module shns_div (
  input  logic               clk,
  input  logic               rst_n,
  input  shns_pkg::div_req_t req,
  output shns_pkg::div_rsp_t rsp
);
  import shns_pkg::*;

  logic [DIV_DW:0]   rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [4:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // Trial subtraction of one step.
  assign trial = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= '0;
        quo_r <= req.dividend;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? trial - {1'b0, req.divisor} : trial;
        quo_r <= {quo_r[DIV_NW-2:0], fits};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r[DIV_DW-1:0];

endmodule

/* rtl/core/spatial_hash_neighbor_search_core.sv */
// Spatial hash grid neighbor search: point store, index build and 3x3 query.
// Depends on shns_pkg and on shns_div, the shared iterative divider.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------------------
//  input   | in_mode, in_pos_x, in_pos_y                  | start high, busy low
//  result  | out_result_kind, out_point_index, out_last   | out_strobe, one cycle
//  config  | cfg_wdata (cell_radius)                      | cfg_we, no wait
//
// Each pass through the shared divider is a start, 32 steps and a done. A build
// computes each point's key (two cell divisions, two multiplies and the modulo)
// and then sorts the keys. A query divides its own position into a cell, hashes
// each visited cell, checks each entry of its run and ends with a final beat.
// Reset clears the count, the built flag and the radius to 1.0; the stores are
// not cleared. The receiver cannot stall; busy is high while an item is at work.
module spatial_hash_neighbor_search_core #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [23:0] in_pos_x,
  input  logic [23:0] in_pos_y,
  output logic        out_strobe,
  output logic [2:0]  out_result_kind,
  output logic [5:0]  out_point_index,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [22:0] cfg_wdata
);
  import shns_pkg::*;

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_R2, S_PT_RD, S_DIVX_GO, S_DIVX_W, S_DIVY_GO, S_DIVY_W,
    S_MULX, S_MULY, S_MOD_GO, S_MOD_W, S_SRT_RD, S_SRT_CMP,
    S_KS_RD, S_KS_W, S_SCAN, S_SCAN_W, S_DX, S_DY, S_CMP, S_FIN
  } state_t;

  state_t state_r;

  // Configuration and persistent state.
  logic [22:0]   radius_r;
  logic [CW-1:0] count_r;
  logic          built_r;

  // Per-item working registers.
  logic                is_query_r;
  logic signed [23:0]  tx_r, ty_r;
  logic signed [24:0]  cx_r, cy_r;
  logic signed [1:0]   ox_r, oy_r;
  logic [IW-1:0]       i_r, k_r, pos_r, key_r;
  logic                found_r;
  logic [CW-1:0]       p_r;
  logic [6:0]          n_r;
  logic                pend_r;
  logic [IW-1:0]       pend_idx_r;
  logic [45:0]         r2_r;
  logic [49:0]         d2_r;
  logic signed [50:0]  prod_r;
  logic [31:0]         hx_r;

  // Output registers.
  logic        out_strobe_r, out_last_r;
  logic [2:0]  out_kind_r;
  logic [5:0]  out_idx_r;

  // Memories and their registered read data.
  logic [23:0]   xs_mem [MAX_POINTS];
  logic [23:0]   ys_mem [MAX_POINTS];
  logic [IW-1:0] keys_mem [MAX_POINTS];
  logic [IW-1:0] spt_mem [MAX_POINTS];
  logic [IW-1:0] skey_mem [MAX_POINTS];
  logic [CW-1:0] kst_mem [MAX_POINTS];
  logic [23:0]   xs_q, ys_q;
  logic [IW-1:0] keys_q, spt_q, skey_q;
  logic [CW-1:0] kst_q;

  // Effective radius: zero acts as one.
  logic [22:0] rad;
  assign rad = (radius_r == '0) ? 23'd1 : radius_r;

  logic          accept;
  logic          full;
  logic [IW-1:0] last_idx;
  assign accept   = start && (state_r == S_IDLE);
  assign full     = count_r == CW'(MAX_POINTS);
  assign last_idx = IW'(count_r - CW'(1));

  // Shared divider.
  div_req_t div_req;
  div_rsp_t div_rsp;
  shns_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Coordinate fed to the cell division.
  logic signed [23:0] src_x, src_y, src;
  logic [23:0]        src_abs;
  logic [23:0]        quot24;
  logic signed [24:0] cell_val;
  assign src_x   = is_query_r ? tx_r : $signed(xs_q);
  assign src_y   = is_query_r ? ty_r : $signed(ys_q);
  assign src     = (state_r == S_DIVY_GO || state_r == S_DIVY_W) ? src_y : src_x;
  assign src_abs = src[23] ? (~src + 24'd1) : src;
  assign quot24  = div_rsp.quot[23:0];
  assign cell_val = src[23] ? -$signed({1'b0, quot24}) : $signed({1'b0, quot24});

  logic [31:0] hash;
  assign hash = hx_r + prod_r[31:0];

  always_comb begin
    div_req = '0;
    div_req.divisor = rad;
    case (state_r)
      S_DIVX_GO, S_DIVY_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'd0, src_abs};
      end
      S_MOD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = hash;
      end
      default: ;
    endcase
    if (state_r == S_MOD_GO || state_r == S_MOD_W) div_req.divisor = 23'(count_r);
  end

  // Shared multiplier.
  logic signed [25:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [24:0] dx, dy;
  assign dx = $signed({xs_q[23], xs_q}) - $signed({tx_r[23], tx_r});
  assign dy = $signed({ys_q[23], ys_q}) - $signed({ty_r[23], ty_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_R2: begin
        mul_a = $signed({3'd0, rad});
        mul_b = $signed({2'd0, rad});
      end
      S_MULX: begin
        mul_a = $signed({cx_r[24], cx_r}) + $signed({{24{ox_r[1]}}, ox_r});
        mul_b = HASH_MUL_X;
      end
      S_MULY: begin
        mul_a = $signed({cy_r[24], cy_r}) + $signed({{24{oy_r[1]}}, oy_r});
        mul_b = HASH_MUL_Y;
      end
      S_DX: begin
        mul_a = $signed({dx[24], dx});
        mul_b = dx;
      end
      S_DY: begin
        mul_a = $signed({dy[24], dy});
        mul_b = dy;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [50:0] d2_sum;
  logic        in_range;
  assign d2_sum   = {1'b0, d2_r} + {1'b0, prod_r[49:0]};
  assign in_range = d2_sum <= {5'd0, r2_r};

  // Memory write controls.
  logic          xs_we, keys_we, srt_we, kst_we;
  logic [IW-1:0] kst_wa;
  logic [CW-1:0] kst_wd;
  logic          srt_hit;
  assign srt_hit = (state_r == S_SRT_CMP) && (keys_q == k_r);
  assign xs_we   = accept && (in_mode == MODE_LOAD) && !full;
  assign keys_we = (state_r == S_MOD_W) && div_rsp.done && !is_query_r;
  assign srt_we  = srt_hit;
  assign kst_we  = keys_we || (srt_hit && !found_r);
  assign kst_wa  = keys_we ? i_r : k_r;
  assign kst_wd  = keys_we ? count_r : CW'(pos_r);

  // Point coordinate store; read address follows the build index or the scan.
  logic [IW-1:0] pt_ra;
  assign pt_ra = is_query_r ? spt_q : i_r;
  always_ff @(posedge clk) begin
    if (xs_we) begin
      xs_mem[count_r[IW-1:0]] <= in_pos_x;
      ys_mem[count_r[IW-1:0]] <= in_pos_y;
    end
    xs_q <= xs_mem[pt_ra];
    ys_q <= ys_mem[pt_ra];
  end

  // Per-point key scratch used by the sort.
  always_ff @(posedge clk) begin
    if (keys_we) keys_mem[i_r] <= div_rsp.rem[IW-1:0];
    keys_q <= keys_mem[i_r];
  end

  // Sorted entries.
  always_ff @(posedge clk) begin
    if (srt_we) begin
      spt_mem[pos_r]  <= i_r;
      skey_mem[pos_r] <= k_r;
    end
    spt_q  <= spt_mem[p_r[IW-1:0]];
    skey_q <= skey_mem[p_r[IW-1:0]];
  end

  // First sorted position of each key.
  always_ff @(posedge clk) begin
    if (kst_we) kst_mem[kst_wa] <= kst_wd;
    kst_q <= kst_mem[key_r];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radius_r     <= 23'd4096;
      count_r      <= '0;
      built_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) radius_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            tx_r <= $signed(in_pos_x);
            ty_r <= $signed(in_pos_y);
            case (in_mode)
              MODE_LOAD: begin
                if (full) begin
                  out_strobe_r <= 1'b1;
                  out_kind_r   <= KIND_REJECTED;
                  out_idx_r    <= '0;
                  out_last_r   <= 1'b1;
                end else begin
                  count_r <= count_r + CW'(1);
                  built_r <= 1'b0;
                end
              end
              MODE_BUILD: begin
                if (count_r == '0) begin
                  built_r      <= 1'b0;
                  out_strobe_r <= 1'b1;
                  out_kind_r   <= KIND_BUILT;
                  out_idx_r    <= '0;
                  out_last_r   <= 1'b1;
                end else begin
                  is_query_r <= 1'b0;
                  i_r        <= '0;
                  ox_r       <= '0;
                  oy_r       <= '0;
                  state_r    <= S_PT_RD;
                end
              end
              MODE_QUERY: begin
                if (!built_r || count_r == '0) begin
                  out_strobe_r <= 1'b1;
                  out_kind_r   <= KIND_NOT_BUILT;
                  out_idx_r    <= '0;
                  out_last_r   <= 1'b1;
                end else begin
                  is_query_r <= 1'b1;
                  ox_r       <= -2'sd1;
                  oy_r       <= -2'sd1;
                  n_r        <= '0;
                  pend_r     <= 1'b0;
                  state_r    <= S_R2;
                end
              end
              default: ;
            endcase
          end
        end
        S_R2: begin
          r2_r    <= mul_p[45:0];
          state_r <= S_DIVX_GO;
        end
        S_PT_RD:   state_r <= S_DIVX_GO;
        S_DIVX_GO: state_r <= S_DIVX_W;
        S_DIVX_W: begin
          if (div_rsp.done) begin
            cx_r    <= cell_val;
            state_r <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: state_r <= S_DIVY_W;
        S_DIVY_W: begin
          if (div_rsp.done) begin
            cy_r    <= cell_val;
            state_r <= S_MULX;
          end
        end
        S_MULX: begin
          prod_r  <= mul_p;
          state_r <= S_MULY;
        end
        S_MULY: begin
          hx_r    <= prod_r[31:0];
          prod_r  <= mul_p;
          state_r <= S_MOD_GO;
        end
        S_MOD_GO: state_r <= S_MOD_W;
        S_MOD_W: begin
          if (div_rsp.done) begin
            key_r <= div_rsp.rem[IW-1:0];
            if (is_query_r) begin
              state_r <= S_KS_RD;
            end else if (i_r == last_idx) begin
              i_r     <= '0;
              k_r     <= '0;
              pos_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_SRT_RD;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_PT_RD;
            end
          end
        end
        // Counting sort: every key against every point, in index order.
        S_SRT_RD: state_r <= S_SRT_CMP;
        S_SRT_CMP: begin
          if (srt_hit) begin
            pos_r   <= pos_r + IW'(1);
            found_r <= 1'b1;
          end
          state_r <= S_SRT_RD;
          if (i_r == last_idx) begin
            i_r     <= '0;
            found_r <= 1'b0;
            k_r     <= k_r + IW'(1);
            if (k_r == last_idx) begin
              built_r      <= 1'b1;
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_BUILT;
              out_idx_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
        // Query scan of one visited cell's key run.
        S_KS_RD: state_r <= S_KS_W;
        S_KS_W: begin
          p_r     <= kst_q;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (p_r < count_r) begin
            state_r <= S_SCAN_W;
          end else begin
            state_r <= S_MULX;
            if (oy_r == 2'sd1) begin
              oy_r <= -2'sd1;
              ox_r <= ox_r + 2'sd1;
              if (ox_r == 2'sd1) state_r <= S_FIN;
            end else begin
              oy_r <= oy_r + 2'sd1;
            end
          end
        end
        S_SCAN_W: begin
          if (skey_q == key_r) begin
            state_r <= S_DX;
          end else begin
            state_r <= S_MULX;
            if (oy_r == 2'sd1) begin
              oy_r <= -2'sd1;
              ox_r <= ox_r + 2'sd1;
              if (ox_r == 2'sd1) state_r <= S_FIN;
            end else begin
              oy_r <= oy_r + 2'sd1;
            end
          end
        end
        S_DX: begin
          prod_r  <= mul_p;
          state_r <= S_DY;
        end
        S_DY: begin
          d2_r    <= prod_r[49:0];
          prod_r  <= mul_p;
          state_r <= S_CMP;
        end
        // A match is held back one beat so the final one can carry last.
        S_CMP: begin
          if (in_range && n_r < 7'(RESULT_CAP)) begin
            if (pend_r) begin
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_NEIGHBOR;
              out_idx_r    <= 6'(pend_idx_r);
              out_last_r   <= 1'b0;
            end
            pend_r     <= 1'b1;
            pend_idx_r <= spt_q;
            n_r        <= n_r + 7'd1;
          end
          p_r     <= p_r + CW'(1);
          state_r <= S_SCAN;
        end
        S_FIN: begin
          out_strobe_r <= 1'b1;
          out_last_r   <= 1'b1;
          out_kind_r   <= pend_r ? KIND_NEIGHBOR : KIND_NONE;
          out_idx_r    <= pend_r ? 6'(pend_idx_r) : 6'd0;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = state_r != S_IDLE;
  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_point_index = out_idx_r;
  assign out_last        = out_last_r;

endmodule

/* verif/spatial_hash_neighbor_search_core_test.sv */
// Self-checking testbench of the spatial hash neighbor search core.
// Depends on shns_pkg and spatial_hash_neighbor_search_core; predicts every result beat.
module spatial_hash_neighbor_search_core_test;
  import shns_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int NPTS = 64;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] index;
    logic       last;
  } beat_t;

  typedef struct {
    logic [1:0]  mode;
    logic [23:0] x;
    logic [23:0] y;
    bit          typed;
    logic [2:0]  kind;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = MODE_LOAD;
  logic [23:0] in_pos_x = '0;
  logic [23:0] in_pos_y = '0;
  logic        out_strobe;
  logic [2:0]  out_result_kind;
  logic [5:0]  out_point_index;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [22:0] cfg_wdata = '0;

  // Predictor state, mirrored from the block.
  logic [23:0] grid_x [NPTS];
  logic [23:0] grid_y [NPTS];
  int          order_point [NPTS];
  int          order_key [NPTS];
  int          first_slot [NPTS];
  int          loaded;
  bit          built;
  logic [22:0] radius;

  beat_t  pending_beats[$];
  beat_t  new_beats[$];
  int     errors = 0;
  longint cycles = 0;
  int     idle_pct = 0;

  spatial_hash_neighbor_search_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_strobe(out_strobe), .out_result_kind(out_result_kind),
    .out_point_index(out_point_index), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("spatial_hash_neighbor_search_core: mismatch");
      $finish;
    end
  end

  // Compare each result beat with the oldest expected one.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat kind=%0d index=%0d", out_result_kind, out_point_index);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, out_result_kind);
          errors++;
        end
        if (out_point_index !== want.index) begin
          $error("point_index: expected %0d, actual %0d", want.index, out_point_index);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  function automatic int eff_radius();
    return (radius == 0) ? 1 : int'(radius);
  endfunction

  // Cell coordinate, truncated toward zero.
  function automatic int cell_of(logic [23:0] pos);
    int p;
    p = int'($signed(pos));
    return p / eff_radius();
  endfunction

  // Bucket of a cell: 32-bit wrapped hash reduced by the point count.
  function automatic int bucket_of(bit [31:0] cx, bit [31:0] cy);
    bit [31:0] h;
    h = cx * 32'd15823 + cy * 32'd9737333;
    return int'(h % loaded);
  endfunction

  task automatic rebuild_index();
    int buckets [NPTS];
    int pos;
    pos = 0;
    for (int i = 0; i < loaded; i++) begin
      buckets[i] = bucket_of(cell_of(grid_x[i]), cell_of(grid_y[i]));
      first_slot[i] = loaded;
    end
    for (int k = 0; k < loaded; k++) begin
      for (int i = 0; i < loaded; i++) begin
        if (buckets[i] == k) begin
          if (first_slot[k] == loaded) first_slot[k] = pos;
          order_point[pos] = i;
          order_key[pos] = k;
          pos++;
        end
      end
    end
    built = 1'b1;
  endtask

  // Fills new_beats with the results of one accepted item and updates state.
  task automatic predict_results(logic [1:0] mode, logic [23:0] x, logic [23:0] y);
    bit [31:0] cx, cy;
    int bucket, p, pi, hits;
    longint dx, dy, r2;
    new_beats = {};
    case (mode)
      MODE_LOAD: begin
        if (loaded >= NPTS) begin
          new_beats.push_back('{KIND_REJECTED, 6'd0, 1'b1});
        end else begin
          grid_x[loaded] = x;
          grid_y[loaded] = y;
          loaded++;
          built = 1'b0;
        end
      end
      MODE_BUILD: begin
        if (loaded == 0) built = 1'b0;
        else rebuild_index();
        new_beats.push_back('{KIND_BUILT, 6'd0, 1'b1});
      end
      MODE_QUERY: begin
        if (!built || loaded == 0) begin
          new_beats.push_back('{KIND_NOT_BUILT, 6'd0, 1'b1});
        end else begin
          hits = 0;
          r2 = longint'(eff_radius()) * longint'(eff_radius());
          cx = cell_of(x);
          cy = cell_of(y);
          for (int ox = -1; ox <= 1; ox++) begin
            for (int oy = -1; oy <= 1; oy++) begin
              bucket = bucket_of(cx + ox, cy + oy);
              p = first_slot[bucket % NPTS];
              while (p < loaded && order_key[p] == bucket) begin
                pi = order_point[p];
                dx = longint'($signed(grid_x[pi])) - longint'($signed(x));
                dy = longint'($signed(grid_y[pi])) - longint'($signed(y));
                if (dx * dx + dy * dy <= r2 && hits < RESULT_CAP) begin
                  new_beats.push_back('{KIND_NEIGHBOR, 6'(pi), 1'b0});
                  hits++;
                end
                p++;
              end
            end
          end
          if (hits == 0) new_beats.push_back('{KIND_NONE, 6'd0, 1'b1});
          else new_beats[hits - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item at the falling edge and hold it until the core takes it.
  task automatic send_item(logic [1:0] mode, logic [23:0] x, logic [23:0] y,
                           bit typed, logic [2:0] kind);
    in_mode = mode;
    in_pos_x = x;
    in_pos_y = y;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_results(mode, x, y);
    if (typed) pending_beats.push_back('{kind, 6'd0, 1'b1});
    else foreach (new_beats[i]) pending_beats.push_back(new_beats[i]);
    @(negedge clk);
    start = 1'b0;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
  endtask

  // Register writes happen only with the core quiet and nothing outstanding.
  task automatic write_radius(logic [22:0] value);
    do @(posedge clk); while (busy || pending_beats.size() != 0);
    repeat (150) @(posedge clk);
    @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(posedge clk);
    radius = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Position: full range, near a stored point, or near the origin.
  function automatic logic [23:0] pick_pos(bit want_y, int src);
    int r;
    r = eff_radius();
    if (r > 4000000) r = 4000000;
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 2 * r)) - 24'(r);
      default: begin
        if (loaded == 0) return 24'($urandom);
        return (want_y ? grid_y[src] : grid_x[src]) + 24'($urandom_range(0, 2 * r)) - 24'(r);
      end
    endcase
  endfunction

  task automatic random_phase(int items, int pct);
    int choice, src;
    idle_pct = pct;
    for (int n = 0; n < items; n++) begin
      choice = $urandom_range(99);
      src = (loaded == 0) ? 0 : $urandom_range(loaded - 1);
      if (choice < 20 && loaded < NPTS)
        send_item(MODE_LOAD, pick_pos(0, src), pick_pos(1, src), 0, '0);
      else if (choice < 28)
        send_item(MODE_BUILD, 24'($urandom), 24'($urandom), 0, '0);
      else if (choice < 31)
        send_item(MODE_UNUSED, 24'($urandom), 24'($urandom), 0, '0);
      else if (choice < 33)
        send_item(MODE_LOAD, 24'($urandom), 24'($urandom), 0, '0);
      else
        send_item(MODE_QUERY, pick_pos(0, src), pick_pos(1, src), 0, '0);
    end
  endtask

  row_t plan [16];

  initial begin
    radius = 23'd4096;
    loaded = 0;
    built = 1'b0;
    plan = '{
      '{MODE_QUERY, 24'd0, 24'd0, 1, KIND_NOT_BUILT},
      '{MODE_BUILD, 24'd0, 24'd0, 1, KIND_BUILT},
      '{MODE_QUERY, 24'd0, 24'd0, 1, KIND_NOT_BUILT},
      '{MODE_LOAD, 24'd0, 24'd0, 0, '0},
      '{MODE_LOAD, 24'h7FFFFF, 24'h7FFFFF, 0, '0},
      '{MODE_LOAD, 24'h800000, 24'h800000, 0, '0},
      '{MODE_LOAD, 24'd4096, 24'd0, 0, '0},
      '{MODE_LOAD, 24'hFFF000, 24'hFFFFFF, 0, '0},
      '{MODE_QUERY, 24'd0, 24'd0, 1, KIND_NOT_BUILT},
      '{MODE_BUILD, 24'd0, 24'd0, 1, KIND_BUILT},
      '{MODE_QUERY, 24'd0, 24'd0, 0, '0},
      '{MODE_QUERY, 24'h7FFFFF, 24'h7FFFFF, 0, '0},
      '{MODE_QUERY, 24'h800000, 24'h800000, 0, '0},
      '{MODE_QUERY, 24'h400000, 24'hC00000, 0, '0},
      '{MODE_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 0, '0},
      '{MODE_QUERY, 24'd2048, 24'd0, 0, '0}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset radius.
    foreach (plan[i]) send_item(plan[i].mode, plan[i].x, plan[i].y, plan[i].typed, plan[i].kind);

    // A zero radius behaves as the smallest one.
    write_radius(23'd0);
    random_phase(100, 0);

    // Widest radius: fill to capacity near the origin, overflow, and saturate a query.
    write_radius(23'h7FFFFF);
    random_phase(100, 88);
    while (loaded < NPTS)
      send_item(MODE_LOAD, 24'($urandom_range(0, 2000000)) - 24'd1000000,
                24'($urandom_range(0, 2000000)) - 24'd1000000, 0, '0);
    send_item(MODE_LOAD, 24'd0, 24'd0, 1, KIND_REJECTED);
    send_item(MODE_BUILD, 24'd0, 24'd0, 1, KIND_BUILT);
    send_item(MODE_QUERY, 24'd0, 24'd0, 0, '0);
    send_item(MODE_QUERY, 24'd1, 24'hFFFFFF, 0, '0);

    write_radius(23'($urandom_range(1, 23'h7FFFFF)));
    random_phase(100, 0);
    write_radius(23'd4096);
    random_phase(100, 7);

    // Drain, then leave room for anything still in flight.
    do @(posedge clk); while (busy || pending_beats.size() != 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("spatial_hash_neighbor_search_core: match");
    end else begin
      $display("spatial_hash_neighbor_search_core: mismatch");
    end
    $finish;
  end

endmodule
